// ----- rtl/clle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package clle_pkg;
   localparam int CMD_WIDTH = 4;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_FIRST = 4'd0,
      CMD_NEXT = 4'd1,
      CMD_PREV = 4'd2,
      CMD_LAST = 4'd3,
      CMD_PUSH_FRONT = 4'd4,
      CMD_PUSH_BACK = 4'd5,
      CMD_PUSH_CURRENT = 4'd6,
      CMD_POP_FRONT = 4'd7,
      CMD_POP_BACK = 4'd8,
      CMD_POP_CURRENT = 4'd9,
      CMD_CLEAN = 4'd10
   } command_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL = 2'd2,
      ST_NO_NEIGHBOR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_FINISH,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic exec;
      logic finish;
   } ctrl_type;
endpackage
`default_nettype wire

// ----- rtl/clle_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface clle_req_if;
   logic valid;
   logic ready;
   logic [3:0] command;
   logic [31:0] value_in;
   modport source (output valid, command, value_in, input ready);
   modport sink (input valid, command, value_in, output ready);
endinterface

interface clle_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] value_out;
   logic has_value;
   logic [1:0] status;
   modport source (output valid, value_out, has_value, status, input ready);
   modport sink (input valid, value_out, has_value, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/clle_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module clle_datapath #(
   parameter int CAPACITY = 256,
   parameter int DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   input wire clle_pkg::ctrl_type ctrl,
   input wire logic [3:0] req_command,
   input wire logic [31:0] req_value_in,
   output logic [31:0] rsp_value_out,
   output logic rsp_has_value,
   output logic [1:0] rsp_status
);
   import clle_pkg::*;
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = AW + 1;
   localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   // Node store split by field so each part has one write port.
   logic [SW-1:0] val_mem [CAPACITY];
   logic [LW-1:0] nxt_mem [CAPACITY];
   logic [LW-1:0] prv_mem [CAPACITY];

   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [LW-1:0] free_ff, free_in, fresh_ff, fresh_in, cnt_ff, cnt_in;
   logic [3:0] cmd_ff;
   logic [SW-1:0] data_ff;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [SW-1:0] rd_val_ff;
   logic [LW-1:0] rd_nxt_ff, rd_prv_ff, rd_free_ff;
   logic [SW-1:0] step_val_ff;
   logic step_ff, step_in;
   logic [31:0] out_val_ff, out_val_in;
   logic out_has_ff, out_has_in;
   status_type out_st_ff, out_st_in;

   logic empty, full;
   logic [LW-1:0] new_node, pv, nx, step_t;

   logic wv_en, wn_en, wp_en;
   logic [AW-1:0] wn_a, wp_a;
   logic [LW-1:0] wn_d, wp_d;

   // The second link write of each field store lands in the cycle after the first.
   logic bn_en_ff, bn_en_in, bp_en_ff, bp_en_in;
   logic [AW-1:0] bn_a_ff, bn_a_in, bp_a_ff, bp_a_in;
   logic [LW-1:0] bn_d_ff, bn_d_in, bp_d_ff, bp_d_in;

   assign empty = (cnt_ff == '0) || (head_ff >= NIL);
   assign full = (cnt_ff >= NIL) || ((free_ff >= NIL) && (fresh_ff >= NIL));
   assign new_node = (free_ff < NIL) ? free_ff : fresh_ff;
   assign pv = (rd_prv_ff < NIL) ? rd_prv_ff : NIL;
   assign nx = (rd_nxt_ff < NIL) ? rd_nxt_ff : NIL;
   assign step_t = (cmd_ff == CMD_NEXT) ? nx : pv;

   always_comb begin
      case (command_type'(cmd_ff))
         CMD_FIRST, CMD_POP_FRONT: tgt_in = head_ff;
         CMD_LAST, CMD_POP_BACK, CMD_PUSH_BACK: tgt_in = tail_ff;
         default: tgt_in = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_command;
         data_ff <= req_value_in[SW-1:0];
      end
      if (ctrl.read) begin
         tgt_ff <= tgt_in;
         rd_val_ff <= val_mem[tgt_in[AW-1:0]];
         rd_nxt_ff <= nxt_mem[tgt_in[AW-1:0]];
         rd_prv_ff <= prv_mem[tgt_in[AW-1:0]];
         rd_free_ff <= nxt_mem[free_ff[AW-1:0]];
      end
      if (ctrl.exec) begin
         step_val_ff <= val_mem[step_t[AW-1:0]];
      end
   end

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      free_in = free_ff; fresh_in = fresh_ff; cnt_in = cnt_ff;
      out_val_in = '0; out_has_in = 1'b0; out_st_in = ST_OK;
      step_in = 1'b0;
      wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
      wn_a = new_node[AW-1:0]; wp_a = new_node[AW-1:0];
      wn_d = NIL; wp_d = NIL;
      bn_en_in = 1'b0; bp_en_in = 1'b0;
      bn_a_in = tgt_ff[AW-1:0]; bp_a_in = tgt_ff[AW-1:0];
      bn_d_in = new_node; bp_d_in = new_node;
      case (command_type'(cmd_ff))
         CMD_FIRST, CMD_LAST: begin
            if (empty) out_st_in = ST_EMPTY;
            else begin
               cur_in = tgt_ff;
               out_val_in = 32'(rd_val_ff);
               out_has_in = 1'b1;
            end
         end
         CMD_NEXT, CMD_PREV: begin
            if (empty) out_st_in = ST_EMPTY;
            else if (cur_ff >= NIL || step_t >= NIL) out_st_in = ST_NO_NEIGHBOR;
            else begin
               cur_in = step_t;
               out_has_in = 1'b1;
               step_in = 1'b1;
            end
         end
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_PUSH_CURRENT: begin
            if (full) out_st_in = ST_FULL;
            else if (!empty && cmd_ff != CMD_PUSH_FRONT && tgt_ff >= NIL)
               out_st_in = ST_NO_NEIGHBOR;
            else begin
               if (free_ff < NIL) free_in = (rd_free_ff < NIL) ? rd_free_ff : NIL;
               else fresh_in = fresh_ff + LW'(1);
               cnt_in = cnt_ff + LW'(1);
               wv_en = 1'b1;
               wn_en = 1'b1;
               wp_en = 1'b1;
               if (empty) begin
                  head_in = new_node; tail_in = new_node; cur_in = new_node;
               end else if (cmd_ff == CMD_PUSH_FRONT) begin
                  wn_d = head_ff;
                  bp_en_in = 1'b1; bp_a_in = head_ff[AW-1:0];
                  head_in = new_node; cur_in = new_node;
               end else begin
                  wn_d = nx; wp_d = tgt_ff;
                  bn_en_in = 1'b1;
                  if (nx < NIL) begin
                     bp_en_in = 1'b1; bp_a_in = nx[AW-1:0];
                  end else tail_in = new_node;
                  cur_in = tgt_ff;
               end
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_POP_CURRENT: begin
            if (empty) out_st_in = ST_EMPTY;
            else if (tgt_ff >= NIL) out_st_in = ST_NO_NEIGHBOR;
            else begin
               out_val_in = 32'(rd_val_ff);
               out_has_in = 1'b1;
               if (pv < NIL) begin
                  wn_en = 1'b1; wn_a = pv[AW-1:0]; wn_d = nx;
               end else head_in = nx;
               if (nx < NIL) begin
                  wp_en = 1'b1; wp_a = nx[AW-1:0]; wp_d = pv;
               end else tail_in = pv;
               cur_in = (nx < NIL) ? nx : pv;
               bn_en_in = 1'b1; bn_d_in = free_ff;
               free_in = tgt_ff;
               cnt_in = cnt_ff - LW'(1);
               if (pv >= NIL && nx >= NIL) begin
                  tail_in = NIL; cur_in = NIL;
               end
            end
         end
         CMD_CLEAN: begin
            head_in = NIL; tail_in = NIL; cur_in = NIL;
            free_in = NIL; fresh_in = '0; cnt_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL; tail_ff <= NIL; cur_ff <= NIL; free_ff <= NIL;
         fresh_ff <= '0; cnt_ff <= '0;
      end else if (ctrl.exec) begin
         head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in;
         free_ff <= free_in; fresh_ff <= fresh_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         out_val_ff <= out_val_in; out_has_ff <= out_has_in; out_st_ff <= out_st_in;
         step_ff <= step_in;
         bn_en_ff <= bn_en_in; bn_a_ff <= bn_a_in; bn_d_ff <= bn_d_in;
         bp_en_ff <= bp_en_in; bp_a_ff <= bp_a_in; bp_d_ff <= bp_d_in;
      end else if (ctrl.finish && step_ff) begin
         out_val_ff <= 32'(step_val_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         if (wv_en) val_mem[new_node[AW-1:0]] <= data_ff;
         if (wn_en) nxt_mem[wn_a] <= wn_d;
         if (wp_en) prv_mem[wp_a] <= wp_d;
      end else if (ctrl.finish) begin
         if (bn_en_ff) nxt_mem[bn_a_ff] <= bn_d_ff;
         if (bp_en_ff) prv_mem[bp_a_ff] <= bp_d_ff;
      end
   end

   assign rsp_value_out = out_val_ff;
   assign rsp_has_value = out_has_ff;
   assign rsp_status = out_st_ff;
endmodule
`default_nettype wire

// ----- rtl/clle_control.sv -----
`timescale 1ns / 1ps
`default_nettype none
module clle_control (
   input wire logic clock,
   input wire logic reset,
   clle_req_if.sink req,
   input wire logic rsp_ready,
   output logic rsp_valid,
   output clle_pkg::ctrl_type ctrl
);
   import clle_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req.valid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = S_FINISH;
         S_FINISH: state_in = S_RESPOND;
         S_RESPOND: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      req.ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            ctrl.load = req.valid;
         end
         S_READ: ctrl.read = 1'b1;
         S_EXEC: ctrl.exec = 1'b1;
         S_FINISH: ctrl.finish = 1'b1;
         S_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/cursor_linked_list_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Doubly linked list of data words in a node store of CAPACITY entries, with
// head, tail, cursor and free list. Each item is handled alone: the node store
// is read, the list registers and first link writes are updated, then the
// second link writes and the neighbor read of next and prev complete. The
// result is presented once the read, exec and finish states have passed, and
// the next item is taken only after the result is, so the unit is through with
// one item before it takes another. The single write port per link field is
// why the second link writes need their own state. Clean passes the same states.
module cursor_linked_list_engine_unit #(
   parameter int CAPACITY = 256,
   parameter int DATA_WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   clle_req_if.sink req,
   clle_rsp_if.source rsp
);
   import clle_pkg::*;
   ctrl_type ctrl;

   clle_control u_control (
      .clock(clock), .reset(reset), .req(req),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .ctrl(ctrl)
   );

   clle_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .req_command(req.command), .req_value_in(req.value_in),
      .rsp_value_out(rsp.value_out), .rsp_has_value(rsp.has_value),
      .rsp_status(rsp.status)
   );
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import clle_pkg::*;

   localparam int NODES = 256;
   localparam int NIL = NODES;
   localparam logic [3:0] CMD_UNUSED = 4'd15;
   localparam int STALL_LIMIT = 6000;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [3:0] cmd;
      logic [31:0] val;
      bit typed;
      logic [31:0] ev;
      bit eh;
      logic [1:0] es;
   } item_type;

   typedef struct {
      logic [31:0] value;
      bit has;
      logic [1:0] status;
   } result_type;

   logic clock;
   logic reset;
   clle_req_if req_if ();
   clle_rsp_if rsp_if ();

   cursor_linked_list_engine_unit u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   logic [31:0] word_mem [NODES];
   int next_mem [NODES];
   int prev_mem [NODES];
   int head_ptr, tail_ptr, cursor_ptr, free_ptr, fresh_cnt, entry_cnt;

   item_type sent_q [$];
   result_type expected_q [$];
   int mismatches = 0;
   int accepted = 0;
   int returned = 0;
   int full_hits = 0;
   int quiet_cycles = 0;
   bit calm = 0;
   bit hold_request = 0;

   function automatic bit list_full();
      return entry_cnt >= NODES || (free_ptr >= NIL && fresh_cnt >= NODES);
   endfunction

   function automatic result_type list_pop();
      result_type r;
      int c, pv, nx;
      r = '{32'd0, 1'b0, ST_OK};
      c = cursor_ptr;
      if (entry_cnt == 0 || head_ptr >= NIL) begin
         r.status = ST_EMPTY;
         return r;
      end
      if (c >= NIL) begin
         r.status = ST_NO_NEIGHBOR;
         return r;
      end
      r.value = word_mem[c];
      r.has = 1'b1;
      pv = prev_mem[c];
      nx = next_mem[c];
      if (pv < NIL) next_mem[pv] = nx; else head_ptr = nx;
      if (nx < NIL) prev_mem[nx] = pv; else tail_ptr = pv;
      cursor_ptr = (nx < NIL) ? nx : pv;
      next_mem[c] = free_ptr;
      free_ptr = c;
      entry_cnt--;
      if (head_ptr >= NIL) begin
         tail_ptr = NIL;
         cursor_ptr = NIL;
      end
      return r;
   endfunction

   function automatic result_type list_push(logic [31:0] data, bit front);
      result_type r;
      int n, nx;
      bit empty;
      r = '{32'd0, 1'b0, ST_OK};
      empty = (entry_cnt == 0 || head_ptr >= NIL);
      if (list_full()) begin
         r.status = ST_FULL;
         return r;
      end
      if (!empty && !front && cursor_ptr >= NIL) begin
         r.status = ST_NO_NEIGHBOR;
         return r;
      end
      if (free_ptr < NIL) begin
         n = free_ptr;
         free_ptr = next_mem[n];
      end else begin
         n = fresh_cnt;
         fresh_cnt++;
      end
      word_mem[n] = data;
      next_mem[n] = NIL;
      prev_mem[n] = NIL;
      entry_cnt++;
      if (empty) begin
         head_ptr = n;
         tail_ptr = n;
         cursor_ptr = n;
      end else if (front) begin
         next_mem[n] = head_ptr;
         prev_mem[head_ptr] = n;
         head_ptr = n;
         cursor_ptr = n;
      end else begin
         nx = next_mem[cursor_ptr];
         prev_mem[n] = cursor_ptr;
         next_mem[n] = nx;
         next_mem[cursor_ptr] = n;
         if (nx < NIL) prev_mem[nx] = n; else tail_ptr = n;
      end
      return r;
   endfunction

   function automatic result_type list_apply(logic [3:0] cmd, logic [31:0] data);
      result_type r;
      bit empty;
      int t;
      r = '{32'd0, 1'b0, ST_OK};
      empty = (entry_cnt == 0 || head_ptr >= NIL);
      case (cmd)
         CMD_FIRST, CMD_LAST: begin
            if (empty) begin
               r.status = ST_EMPTY;
            end else begin
               cursor_ptr = (cmd == CMD_FIRST) ? head_ptr : tail_ptr;
               r.value = word_mem[cursor_ptr];
               r.has = 1'b1;
            end
         end
         CMD_NEXT, CMD_PREV: begin
            if (empty) begin
               r.status = ST_EMPTY;
            end else if (cursor_ptr >= NIL) begin
               r.status = ST_NO_NEIGHBOR;
            end else begin
               t = (cmd == CMD_NEXT) ? next_mem[cursor_ptr] : prev_mem[cursor_ptr];
               if (t >= NIL) begin
                  r.status = ST_NO_NEIGHBOR;
               end else begin
                  cursor_ptr = t;
                  r.value = word_mem[t];
                  r.has = 1'b1;
               end
            end
         end
         CMD_PUSH_FRONT: r = list_push(data, 1'b1);
         CMD_PUSH_BACK: begin
            if (!list_full()) cursor_ptr = tail_ptr;
            r = list_push(data, 1'b0);
         end
         CMD_PUSH_CURRENT: r = list_push(data, 1'b0);
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (!empty) cursor_ptr = (cmd == CMD_POP_FRONT) ? head_ptr : tail_ptr;
            r = list_pop();
         end
         CMD_POP_CURRENT: r = list_pop();
         CMD_CLEAN: begin
            head_ptr = NIL;
            tail_ptr = NIL;
            cursor_ptr = NIL;
            free_ptr = NIL;
            fresh_cnt = 0;
            entry_cnt = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      item_type it;
      result_type p, e;
      if (!reset && req_if.valid && req_if.ready) begin
         it = sent_q.pop_front();
         p = list_apply(req_if.command, req_if.value_in);
         if (p.status == ST_FULL) full_hits++;
         if (it.typed) expected_q.push_back('{it.ev, it.eh, it.es});
         else expected_q.push_back(p);
         accepted++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         returned++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
         end else begin
            e = expected_q.pop_front();
            if (rsp_if.value_out !== e.value || rsp_if.has_value !== e.has ||
                rsp_if.status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch at %0t: expected value %h has %0d status %0d, got %h %0d %0d",
                           $realtime, e.value, e.has, e.status,
                           rsp_if.value_out, rsp_if.has_value, rsp_if.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int n;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send(item_type it);
      int gap;
      sent_q.push_back(it);
      req_if.valid <= 1'b1;
      req_if.command <= it.cmd;
      req_if.value_in <= it.val;
      do @(posedge clock); while (!req_if.ready);
      gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_cmd(logic [3:0] cmd, logic [31:0] val);
      send('{cmd, val, 1'b0, 32'd0, 1'b0, ST_OK});
   endtask

   function automatic logic [3:0] pick_cmd(int push_weight);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_weight) return 4'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_CURRENT));
      if (r < push_weight + 30) return 4'($urandom_range(CMD_FIRST, CMD_LAST));
      if (r < 96) return 4'($urandom_range(CMD_POP_FRONT, CMD_POP_CURRENT));
      if (r < 98) return CMD_CLEAN;
      return 4'($urandom_range(11, 15));
   endfunction

   item_type directed [] = '{
      '{CMD_FIRST, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_NEXT, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_PREV, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_LAST, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_POP_FRONT, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_POP_BACK, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_POP_CURRENT, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_CLEAN, 32'hFFFFFFFF, 1, 32'h0, 0, ST_OK},
      '{CMD_UNUSED, 32'h0, 1, 32'h0, 0, ST_OK},
      '{CMD_PUSH_FRONT, 32'h0, 1, 32'h0, 0, ST_OK},
      '{CMD_NEXT, 32'h0, 1, 32'h0, 0, ST_NO_NEIGHBOR},
      '{CMD_PUSH_BACK, 32'hFFFFFFFF, 1, 32'h0, 0, ST_OK},
      '{CMD_FIRST, 32'h0, 1, 32'h0, 1, ST_OK},
      '{CMD_NEXT, 32'h0, 1, 32'hFFFFFFFF, 1, ST_OK},
      '{CMD_NEXT, 32'h0, 1, 32'h0, 0, ST_NO_NEIGHBOR},
      '{CMD_PREV, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_PUSH_CURRENT, 32'h5A5A5A5A, 0, 32'h0, 0, ST_OK},
      '{CMD_PUSH_FRONT, 32'h80000001, 0, 32'h0, 0, ST_OK},
      '{CMD_LAST, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_POP_CURRENT, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_POP_FRONT, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_POP_BACK, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_POP_CURRENT, 32'h0, 0, 32'h0, 0, ST_OK},
      '{CMD_POP_CURRENT, 32'h0, 1, 32'h0, 0, ST_EMPTY},
      '{CMD_PUSH_CURRENT, 32'h12345678, 0, 32'h0, 0, ST_OK}
   };

   initial begin
      int drain;
      req_if.valid <= 1'b0;
      req_if.command <= CMD_FIRST;
      req_if.value_in <= 32'd0;
      reset <= 1'b1;
      head_ptr = NIL;
      tail_ptr = NIL;
      cursor_ptr = NIL;
      free_ptr = NIL;
      fresh_cnt = 0;
      entry_cnt = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send(directed[i]);

      repeat (60) send_cmd(pick_cmd(45), $urandom());

      // Receiver holds off while the sender keeps offering items.
      hold_request = 1;
      repeat (20) send_cmd(pick_cmd(50), $urandom());

      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      @(posedge clock);

      // Fill the store completely, then run against the full store.
      send_cmd(CMD_CLEAN, $urandom());
      repeat (NODES + 4)
         send_cmd(4'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_CURRENT)), $urandom());
      repeat (10) send_cmd(4'($urandom_range(CMD_FIRST, CMD_LAST)), $urandom());
      repeat (6) send_cmd(4'($urandom_range(CMD_POP_FRONT, CMD_POP_CURRENT)), 32'd0);
      repeat (8) send_cmd(4'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_CURRENT)), $urandom());

      repeat (40) send_cmd(pick_cmd(35), $urandom());
      calm = 1;
      repeat (30) send_cmd(pick_cmd(40), $urandom());
      req_if.valid <= 1'b0;

      drain = 0;
      while (expected_q.size() != 0 && drain < STALL_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);

      $display("Sent %0d items and checked %0d results; the store hit the full limit %0d times.",
               accepted, returned, full_hits);
      $display("Covered moves, pushes, pops, clean and unused codes with random stalls on both sides.");
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Mismatches: %0d, results still outstanding: %0d", mismatches,
                  expected_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
